// File: design/ppfm_pkg.sv
// ----------------------------------------------------------------------------
// ppfm_pkg
// Shared widths, constants, register codes and types of the pitch-priority
// X-fin mixer.
// ----------------------------------------------------------------------------
package ppfm_pkg;

	// Fixed-point formats.
	localparam int ANGLE_FRAC_BITS = 8;
	localparam int SCALE_FRAC_BITS = 16;

	// Field widths.
	localparam int FIELD_W = 17;
	localparam int LIM_W   = 16;
	localparam int MASK_W  = 4;
	localparam int LAT_W   = FIELD_W + 1;
	localparam int ABS_W   = FIELD_W + 1;
	localparam int K_W     = SCALE_FRAC_BITS + 1;
	localparam int PROD_W  = K_W + 1 + LAT_W;
	localparam int SUM_W   = PROD_W + 1;
	localparam int CNT_W   = $clog2(SCALE_FRAC_BITS + 1);

	// Pitch gives up 45 degrees of the servo range to the lateral terms.
	localparam int PITCH_OFS = 45 << ANGLE_FRAC_BITS;

	// Unscaled lateral gain.
	localparam logic [K_W-1:0] K_ONE = {1'b1, {SCALE_FRAC_BITS{1'b0}}};

	// Stream payload widths, padded to whole bytes.
	localparam int NUM_IN      = 3;
	localparam int NUM_OUT     = 5;
	localparam int IN_TDATA_W  = ((NUM_IN * FIELD_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((NUM_OUT * FIELD_W + 7) / 8) * 8;

	// Job queue between front and back.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Configuration port.
	localparam int CFG_ADDR_W = 8;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_ADDR_W-1:0] REG_SERVO_LIMIT = 8'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_FIN_MASK    = 8'd1;
	localparam logic [LIM_W-1:0]      LIMIT_RESET     = 16'd23040;
	localparam logic [MASK_W-1:0]     MASK_RESET      = 4'd0;

	// One classified command on its way from front to back.
	typedef struct packed {
		logic signed [FIELD_W-1:0] pitch;    // clamped pitch
		logic signed [LAT_W-1:0]   lat_sum;  // roll + yaw
		logic signed [LAT_W-1:0]   lat_diff; // yaw - roll
		logic [LIM_W-1:0]          num;      // limit - |pitch|
		logic [ABS_W-1:0]          amax;     // largest lateral magnitude
		logic                      bypass;   // gain stays at one, no divide
	} ppfm_job_t;

	// One result; fin_up_left sits in the lowest bits.
	typedef struct packed {
		logic [FIELD_W-1:0]        lateral_scale;
		logic signed [FIELD_W-1:0] fin_down_left;
		logic signed [FIELD_W-1:0] fin_down_right;
		logic signed [FIELD_W-1:0] fin_up_right;
		logic signed [FIELD_W-1:0] fin_up_left;
	} ppfm_result_t;

	// Back-end sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DIV  = 4'b0010,
		ST_MUL  = 4'b0100,
		ST_FIN  = 4'b1000
	} ppfm_state_t;

endpackage

// File: design/ppfm_front.sv
// ----------------------------------------------------------------------------
// ppfm_front
// Front end: clamps pitch, forms the lateral terms and classifies each
// command as needing a gain divide or keeping unit gain.
// ----------------------------------------------------------------------------
module ppfm_front import ppfm_pkg::*; (
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [FIELD_W-1:0] pitch_cmd,
	input  logic signed [FIELD_W-1:0] roll_cmd,
	input  logic signed [FIELD_W-1:0] yaw_cmd,
	input  logic [LIM_W-1:0]          fin_travel_limit,
	output logic                      job_valid,
	input  logic                      job_ready,
	output ppfm_job_t                 job
);

	logic [LIM_W-1:0]          pitch_lim;
	logic signed [FIELD_W:0]   pitch_ext;
	logic signed [FIELD_W:0]   plim_pos;
	logic signed [FIELD_W:0]   plim_neg;
	logic signed [FIELD_W-1:0] pitch_cl;
	logic [LIM_W-1:0]          pitch_abs;
	logic signed [LAT_W-1:0]   lat_sum;
	logic signed [LAT_W-1:0]   lat_diff;
	logic [ABS_W-1:0]          abs_sum;
	logic [ABS_W-1:0]          abs_diff;
	logic [ABS_W-1:0]          amax;
	logic [LIM_W-1:0]          num;

	// Pitch limit is the servo limit less 45 degrees, never below zero.
	always_comb begin
		if (32'(fin_travel_limit) > PITCH_OFS) begin
			pitch_lim = LIM_W'(32'(fin_travel_limit) - PITCH_OFS);
		end else begin
			pitch_lim = '0;
		end
	end

	// Clamp pitch to the symmetric pitch limit.
	always_comb begin
		pitch_ext = (FIELD_W + 1)'(pitch_cmd);
		plim_pos  = signed'((FIELD_W + 1)'(pitch_lim));
		plim_neg  = -plim_pos;
		if (pitch_ext > plim_pos) begin
			pitch_cl = FIELD_W'(plim_pos);
		end else if (pitch_ext < plim_neg) begin
			pitch_cl = FIELD_W'(plim_neg);
		end else begin
			pitch_cl = pitch_cmd;
		end
		pitch_abs = pitch_cl[FIELD_W-1] ? LIM_W'(-pitch_cl) : LIM_W'(pitch_cl);
	end

	// Lateral terms; the other two fins carry their negations.
	always_comb begin
		lat_sum  = LAT_W'(roll_cmd) + LAT_W'(yaw_cmd);
		lat_diff = LAT_W'(yaw_cmd) - LAT_W'(roll_cmd);
		abs_sum  = lat_sum[LAT_W-1] ? ABS_W'(-lat_sum) : ABS_W'(lat_sum);
		abs_diff = lat_diff[LAT_W-1] ? ABS_W'(-lat_diff) : ABS_W'(lat_diff);
		amax     = (abs_sum > abs_diff) ? abs_sum : abs_diff;
		num      = fin_travel_limit - pitch_abs;
	end

	// The tightest fin sets the gain: num / amax, held at one when that is
	// at least one or when every lateral term is zero.
	always_comb begin
		job.pitch    = pitch_cl;
		job.lat_sum  = lat_sum;
		job.lat_diff = lat_diff;
		job.num      = num;
		job.amax     = amax;
		job.bypass   = (amax == '0) || (ABS_W'(num) >= amax);
	end

	assign job_valid = in_valid;
	assign in_ready  = job_ready;

endmodule

// File: design/ppfm_queue.sv
// ----------------------------------------------------------------------------
// ppfm_queue
// Short job queue that lets the front end keep taking beats while the back
// end divides.
// ----------------------------------------------------------------------------
module ppfm_queue import ppfm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push_valid,
	output logic      push_ready,
	input  ppfm_job_t push_job,
	output logic      pop_valid,
	input  logic      pop_ready,
	output ppfm_job_t pop_job
);

	ppfm_job_t         entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_job    = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Job storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

// File: design/ppfm_back.sv
// ----------------------------------------------------------------------------
// ppfm_back
// Back end: restoring divider for the lateral gain, two gain multipliers and
// the fin output register.
// ----------------------------------------------------------------------------
module ppfm_back import ppfm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_valid,
	output logic              job_ready,
	input  ppfm_job_t         job,
	input  logic [MASK_W-1:0] fin_sign_mask,
	output logic              out_valid,
	input  logic              out_ready,
	output ppfm_result_t      result
);

	ppfm_state_t                state_q;
	logic [CNT_W-1:0]           cnt_q;
	logic signed [FIELD_W-1:0]  pitch_q;
	logic signed [LAT_W-1:0]    lat_sum_q;
	logic signed [LAT_W-1:0]    lat_diff_q;
	logic [ABS_W-1:0]           amax_q;
	logic [ABS_W:0]             rem_q;
	logic [SCALE_FRAC_BITS-1:0] quo_q;
	logic [K_W-1:0]             k_q;
	logic signed [PROD_W-1:0]   prod_sum_q;
	logic signed [PROD_W-1:0]   prod_diff_q;
	logic                       out_valid_q;
	ppfm_result_t               result_q;
	logic [ABS_W:0]             rem_shift;
	logic                       rem_ge;
	logic [ABS_W:0]             rem_next;
	logic [SCALE_FRAC_BITS-1:0] quo_next;
	logic                       out_load;

	// One fin: truncate (pitch*one + k*L) / one toward zero, then apply sign.
	function automatic logic signed [FIELD_W-1:0] fin_calc(
		input logic signed [FIELD_W-1:0] p,
		input logic signed [PROD_W-1:0]  prod,
		input logic                      neg
	);
		logic signed [SUM_W-1:0]   s;
		logic signed [SUM_W-1:0]   q;
		logic signed [FIELD_W-1:0] v;
		s = (SUM_W'(p) <<< SCALE_FRAC_BITS) + SUM_W'(prod);
		q = s >>> SCALE_FRAC_BITS;
		if (s[SUM_W-1] && (|s[SCALE_FRAC_BITS-1:0])) begin
			q = q + SUM_W'(1);
		end
		v = q[FIELD_W-1:0];
		if (neg) begin
			v = -v;
		end
		return v;
	endfunction

	// One restoring divide step per cycle.
	always_comb begin
		rem_shift = {rem_q[ABS_W-1:0], 1'b0};
		rem_ge    = (rem_shift >= {1'b0, amax_q});
		rem_next  = rem_ge ? rem_shift - {1'b0, amax_q} : rem_shift;
		quo_next  = {quo_q[SCALE_FRAC_BITS-2:0], rem_ge};
	end

	assign job_ready = (state_q == ST_IDLE);
	assign out_load  = (state_q == ST_FIN) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign result    = result_q;

	// Sequencer and handshake state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						cnt_q   <= CNT_W'(SCALE_FRAC_BITS);
						state_q <= job.bypass ? ST_MUL : ST_DIV;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNT_W'(1)) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (job_valid) begin
					pitch_q    <= job.pitch;
					lat_sum_q  <= job.lat_sum;
					lat_diff_q <= job.lat_diff;
					amax_q     <= job.amax;
					rem_q      <= (ABS_W + 1)'(job.num);
					quo_q      <= '0;
					k_q        <= K_ONE;
				end
			end
			ST_DIV: begin
				rem_q <= rem_next;
				quo_q <= quo_next;
				if (cnt_q == CNT_W'(1)) begin
					k_q <= K_W'(quo_next);
				end
			end
			ST_MUL: begin
				prod_sum_q  <= signed'({1'b0, k_q}) * lat_sum_q;
				prod_diff_q <= signed'({1'b0, k_q}) * lat_diff_q;
			end
			ST_FIN: begin
				if (out_load) begin
					result_q.fin_up_left    <= fin_calc(pitch_q, prod_sum_q, fin_sign_mask[0]);
					result_q.fin_up_right   <= fin_calc(pitch_q, -prod_sum_q, fin_sign_mask[1]);
					result_q.fin_down_right <= fin_calc(pitch_q, prod_diff_q, fin_sign_mask[2]);
					result_q.fin_down_left  <= fin_calc(pitch_q, -prod_diff_q, fin_sign_mask[3]);
					result_q.lateral_scale  <= FIELD_W'(k_q);
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// File: design/pitch_priority_fin_mixer_top.sv
// ----------------------------------------------------------------------------
// pitch_priority_fin_mixer_top
// Pitch-priority X-fin mixer with a common lateral desaturation gain.
//
//   channel   direction  beat contents (lowest bits first)
//   s_axis    in         pitch_cmd, roll_cmd, yaw_cmd (17 bit signed each)
//   m_axis    out        fin_up_left, fin_up_right, fin_down_right,
//                        fin_down_left (17 bit signed), lateral_scale (17 bit)
//   cfg       in         cfg_addr 0 fin_travel_limit, 1 fin_sign_mask
//
// The back end loads a beat, runs 16 restoring divider steps when the gain
// must be divided out (none when it stays one), then multiplies and writes
// the output register; the shared restoring divider sets the sustained rate.
// A two-entry queue takes input beats while the back end works, and the
// output register holds a result while the next one is computed.
// Reset sets the limit to 90 degrees and clears the sign mask.
// ----------------------------------------------------------------------------
module pitch_priority_fin_mixer_top import ppfm_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// pitch_cmd [16:0], roll_cmd [33:17], yaw_cmd [50:34], zero pad
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// fin_up_left, fin_up_right, fin_down_right, fin_down_left,
	// lateral_scale, 17 bits each from bit 0, zero pad
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic [LIM_W-1:0]  fin_travel_limit_q;
	logic [MASK_W-1:0] fin_sign_mask_q;
	logic              push_valid;
	logic              push_ready;
	ppfm_job_t         push_job;
	logic              pop_valid;
	logic              pop_ready;
	ppfm_job_t         pop_job;
	ppfm_result_t      result;

	// Configuration registers; unknown indexes are ignored.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_travel_limit_q <= LIMIT_RESET;
			fin_sign_mask_q    <= MASK_RESET;
		end else if (cfg_valid) begin
			case (cfg_addr)
				REG_SERVO_LIMIT: fin_travel_limit_q <= LIM_W'(cfg_data);
				REG_FIN_MASK:    fin_sign_mask_q    <= MASK_W'(cfg_data);
				default: begin
				end
			endcase
		end
	end

	// Front end classifies each command beat.
	ppfm_front u_front (
		.in_valid         (s_axis_tvalid),
		.in_ready         (s_axis_tready),
		.pitch_cmd        (s_axis_tdata[FIELD_W-1:0]),
		.roll_cmd         (s_axis_tdata[2*FIELD_W-1:FIELD_W]),
		.yaw_cmd          (s_axis_tdata[3*FIELD_W-1:2*FIELD_W]),
		.fin_travel_limit (fin_travel_limit_q),
		.job_valid        (push_valid),
		.job_ready        (push_ready),
		.job              (push_job)
	);

	ppfm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_job    (pop_job)
	);

	ppfm_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.job_valid     (pop_valid),
		.job_ready     (pop_ready),
		.job           (pop_job),
		.fin_sign_mask (fin_sign_mask_q),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.result        (result)
	);

	// Pack the result beat.
	assign m_axis_tdata = {{(OUT_TDATA_W - NUM_OUT * FIELD_W){1'b0}}, result};

endmodule

// File: design/ppfm_checker.sv
// ----------------------------------------------------------------------------
// ppfm_checker
// Port-level checks on the fin mixer output stream.
// ----------------------------------------------------------------------------
module ppfm_checker import ppfm_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	localparam logic [FIELD_W-1:0] FIN_MIN = {1'b1, {(FIELD_W - 1){1'b0}}};

	logic [FIELD_W-1:0] fin0;
	logic [FIELD_W-1:0] fin1;
	logic [FIELD_W-1:0] fin2;
	logic [FIELD_W-1:0] fin3;
	logic [FIELD_W-1:0] scale;

	assign fin0  = m_axis_tdata[FIELD_W-1:0];
	assign fin1  = m_axis_tdata[2*FIELD_W-1:FIELD_W];
	assign fin2  = m_axis_tdata[3*FIELD_W-1:2*FIELD_W];
	assign fin3  = m_axis_tdata[4*FIELD_W-1:3*FIELD_W];
	assign scale = m_axis_tdata[5*FIELD_W-1:4*FIELD_W];

	// The applied gain never exceeds one.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (32'(scale) <= 32'(K_ONE)))
		else $error("lateral scale above one");

	// A fin stays within the limit, so it never shows the most negative code.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(fin0 == FIN_MIN || fin1 == FIN_MIN ||
			fin2 == FIN_MIN || fin3 == FIN_MIN))
		else $error("fin angle beyond servo range");

	// A stalled result beat holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("output beat changed while stalled");

endmodule

bind pitch_priority_fin_mixer_top ppfm_checker u_ppfm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
